### design/pad_pkg.sv
package pad_pkg;

    // Fixed-point scaling of the rotation datapath.
    localparam int FRAC_SHIFT = 24;

    // Length of the arctangent table; more iterations than this are not run.
    localparam int TABLE_LEN = 24;

    // Arctangent table entries and the angle accumulator (1/256 centidegree).
    localparam int ATAN_BITS = 21;
    localparam int ZW = 23;

    // atan(2^-i) in units of 1/256 centidegree, rounded to nearest.
    localparam logic [ATAN_BITS-1:0] ATAN_TAB [TABLE_LEN] = '{
        21'd1152000, 21'd680065, 21'd359328, 21'd182400,
        21'd91554,   21'd45822,  21'd22916,  21'd11459,
        21'd5730,    21'd2865,   21'd1432,   21'd716,
        21'd358,     21'd179,    21'd90,     21'd45,
        21'd22,      21'd11,     21'd6,      21'd3,
        21'd1,       21'd1,      21'd0,      21'd0
    };

    // Accumulator clamp: a quarter turn in 1/256 centidegree.
    localparam logic [ZW-2:0] Z_QUARTER = 22'd2304000;
    localparam logic [ZW-2:0] Z_ROUND   = 22'd128;

    // Angles in centidegrees.
    localparam logic [15:0] ANGLE_ZERO    = 16'd0;
    localparam logic [15:0] ANGLE_QUARTER = 16'd9000;
    localparam logic [15:0] ANGLE_HALF    = 16'd18000;
    localparam logic [15:0] ANGLE_3QUART  = 16'd27000;
    localparam logic [15:0] FULL_TURN     = 16'd36000;

    // Quadrant codes.
    localparam logic [1:0] QUAD_TOP_RIGHT    = 2'd0;
    localparam logic [1:0] QUAD_TOP_LEFT     = 2'd1;
    localparam logic [1:0] QUAD_BOTTOM_LEFT  = 2'd2;
    localparam logic [1:0] QUAD_BOTTOM_RIGHT = 2'd3;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y = 1'd1;

    // Centre coordinate after reset.
    localparam int RESET_CENTER = 200;

    // Side information that travels with each request through the rotator.
    typedef struct packed {
        logic [1:0] quadrant;
        logic       on_axis;
        logic       at_center;
    } meta_t;

endpackage

### design/pad_fold.sv
module pad_fold
    import pad_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int CTR_BITS   = 10,
    parameter int W          = 37
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] x_coord,
    input  logic [COORD_BITS-1:0] y_coord,
    input  logic [CTR_BITS-1:0]   center_x,
    input  logic [CTR_BITS-1:0]   center_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [W-1:0]   x_out,
    output logic signed [W-1:0]   y_out,
    output meta_t                 meta_out
);

    logic                      valid_reg;
    logic signed [W-1:0]       x_reg, x_next;
    logic signed [W-1:0]       y_reg, y_next;
    meta_t                     meta_reg, meta_next;
    logic signed [CTR_BITS:0]  dx, dy;
    logic [CTR_BITS:0]         abs_dx, abs_dy;
    logic                      dx_zero, dy_zero, dx_pos, dy_pos;

    // Offsets from the centre, with y turned so that up is positive.
    always_comb begin
        dx = $signed({1'b0, CTR_BITS'(x_coord)}) - $signed({1'b0, center_x});
        dy = $signed({1'b0, center_y}) - $signed({1'b0, CTR_BITS'(y_coord)});
        abs_dx = dx[CTR_BITS] ? -dx : dx;
        abs_dy = dy[CTR_BITS] ? -dy : dy;
        dx_zero = (dx == '0);
        dy_zero = (dy == '0);
        dx_pos  = !dx[CTR_BITS] && !dx_zero;
        dy_pos  = !dy[CTR_BITS] && !dy_zero;
    end

    // Quadrant and on-axis classification.
    always_comb begin
        meta_next.at_center = dx_zero && dy_zero;
        meta_next.on_axis   = dx_zero || dy_zero;
        if (dx_zero && dy_zero) begin
            meta_next.quadrant = QUAD_TOP_RIGHT;
        end else if (dy_zero) begin
            meta_next.quadrant = dx_pos ? QUAD_TOP_RIGHT : QUAD_BOTTOM_LEFT;
        end else if (dx_zero) begin
            meta_next.quadrant = dy_pos ? QUAD_TOP_LEFT : QUAD_BOTTOM_RIGHT;
        end else if (dx_pos && dy_pos) begin
            meta_next.quadrant = QUAD_TOP_RIGHT;
        end else if (!dx_pos && dy_pos) begin
            meta_next.quadrant = QUAD_TOP_LEFT;
        end else if (!dx_pos) begin
            meta_next.quadrant = QUAD_BOTTOM_LEFT;
        end else begin
            meta_next.quadrant = QUAD_BOTTOM_RIGHT;
        end
    end

    // Folded magnitudes scaled into the rotator's fixed-point format.
    always_comb begin
        x_next = $signed({{(W-CTR_BITS-FRAC_SHIFT){1'b0}}, abs_dx[CTR_BITS-1:0],
                          {FRAC_SHIFT{1'b0}}});
        y_next = $signed({{(W-CTR_BITS-FRAC_SHIFT){1'b0}}, abs_dy[CTR_BITS-1:0],
                          {FRAC_SHIFT{1'b0}}});
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            meta_reg <= meta_next;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign meta_out  = meta_reg;

endmodule

### design/pad_cordic_stage.sv
module pad_cordic_stage
    import pad_pkg::*;
#(
    parameter int W    = 37,
    parameter int STEP = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [W-1:0]  x_in,
    input  logic signed [W-1:0]  y_in,
    input  logic signed [ZW-1:0] z_in,
    input  meta_t                meta_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [W-1:0]  x_out,
    output logic signed [W-1:0]  y_out,
    output logic signed [ZW-1:0] z_out,
    output meta_t                meta_out
);

    logic                 valid_reg;
    logic signed [W-1:0]  x_reg, x_next;
    logic signed [W-1:0]  y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    meta_t                meta_reg;
    logic signed [W-1:0]  xs, ys;
    logic signed [ZW-1:0] step_angle;

    // One vectoring micro-rotation; the arithmetic shift rounds toward minus infinity.
    always_comb begin
        xs = x_in >>> STEP;
        ys = y_in >>> STEP;
        step_angle = $signed({{(ZW-ATAN_BITS){1'b0}}, ATAN_TAB[STEP]});
        if (!y_in[W-1]) begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + step_angle;
        end else begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - step_angle;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            meta_reg <= meta_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign meta_out  = meta_reg;

endmodule

### design/pad_unfold.sv
module pad_unfold
    import pad_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [ZW-1:0] z_in,
    input  meta_t                meta_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [15:0]          m_angle_centideg,
    output logic [1:0]           m_quadrant_code,
    output logic                 m_at_center
);

    logic          valid_reg;
    logic [15:0]   angle_reg, angle_next;
    logic [1:0]    quad_reg;
    logic          center_reg;
    logic [ZW-2:0] z_clamped;
    logic [ZW-2:0] z_rounded;
    logic [15:0]   t;

    // Clamp the accumulator to a quarter turn and round to centidegrees.
    always_comb begin
        if (z_in[ZW-1]) begin
            z_clamped = '0;
        end else if (z_in[ZW-2:0] > Z_QUARTER) begin
            z_clamped = Z_QUARTER;
        end else begin
            z_clamped = z_in[ZW-2:0];
        end
        z_rounded = z_clamped + Z_ROUND;
        t = 16'(z_rounded[ZW-2:8]);
    end

    // Unfold the first-quadrant angle; points on an axis take the axis angle.
    always_comb begin
        case (meta_in.quadrant)
            QUAD_TOP_RIGHT: begin
                angle_next = meta_in.on_axis ? ANGLE_ZERO : t;
            end
            QUAD_TOP_LEFT: begin
                angle_next = meta_in.on_axis ? ANGLE_QUARTER : ANGLE_HALF - t;
            end
            QUAD_BOTTOM_LEFT: begin
                angle_next = meta_in.on_axis ? ANGLE_HALF : ANGLE_HALF + t;
            end
            default: begin
                if (meta_in.on_axis) begin
                    angle_next = ANGLE_3QUART;
                end else if (t == ANGLE_ZERO) begin
                    angle_next = ANGLE_ZERO;
                end else begin
                    angle_next = FULL_TURN - t;
                end
            end
        endcase
    end

    assign in_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            angle_reg  <= angle_next;
            quad_reg   <= meta_in.quadrant;
            center_reg <= meta_in.at_center;
        end
    end

    assign m_valid          = valid_reg;
    assign m_angle_centideg = angle_reg;
    assign m_quadrant_code  = quad_reg;
    assign m_at_center      = center_reg;

endmodule

### design/point_angle_degrees.sv
// Pipeline from request accept to result valid: one fold stage, one register per CORDIC
// micro-rotation, one output stage.
// Throughput: one request per cycle while results are taken; a full stage holds while its successor cannot take.
// Reset (aresetn low, synchronous): all stage valid bits clear, both centre
// registers return to 200. There is no clearing pass.
module point_angle_degrees
    import pad_pkg::*;
#(
    parameter int COORD_BITS        = 10,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]     cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [COORD_BITS-1:0]     s_x_coord,
    input  logic [COORD_BITS-1:0]     s_y_coord,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [15:0]               m_angle_centideg,
    output logic [1:0]                m_quadrant_code,
    output logic                      m_at_center
);

    // The centre registers must hold their reset value even for narrow coordinates.
    localparam int CTR_BITS = (COORD_BITS > 8) ? COORD_BITS : 8;
    localparam int W        = CTR_BITS + FRAC_SHIFT + 3;
    localparam int NSTEP    = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS
                                                               : TABLE_LEN;

    logic [CTR_BITS-1:0] center_x_reg, center_x_next;
    logic [CTR_BITS-1:0] center_y_reg, center_y_next;

    logic                 pipe_valid [NSTEP+1];
    logic                 pipe_ready [NSTEP+1];
    logic signed [W-1:0]  pipe_x     [NSTEP+1];
    logic signed [W-1:0]  pipe_y     [NSTEP+1];
    logic signed [ZW-1:0] pipe_z     [NSTEP+1];
    meta_t                pipe_meta  [NSTEP+1];

    // Configuration register decode.
    always_comb begin
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CENTER_X: center_x_next = CTR_BITS'(cfg_wr_data);
                REG_CENTER_Y: center_y_next = CTR_BITS'(cfg_wr_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= CTR_BITS'(RESET_CENTER);
            center_y_reg <= CTR_BITS'(RESET_CENTER);
        end else begin
            center_x_reg <= center_x_next;
            center_y_reg <= center_y_next;
        end
    end

    // Offset, fold and scale.
    pad_fold #(
        .COORD_BITS (COORD_BITS),
        .CTR_BITS   (CTR_BITS),
        .W          (W)
    ) u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .x_coord   (s_x_coord),
        .y_coord   (s_y_coord),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .out_valid (pipe_valid[0]),
        .out_ready (pipe_ready[0]),
        .x_out     (pipe_x[0]),
        .y_out     (pipe_y[0]),
        .meta_out  (pipe_meta[0])
    );

    assign pipe_z[0] = '0;

    // Unrolled CORDIC, one registered micro-rotation per stage.
    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        pad_cordic_stage #(
            .W    (W),
            .STEP (k)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (pipe_valid[k]),
            .in_ready  (pipe_ready[k]),
            .x_in      (pipe_x[k]),
            .y_in      (pipe_y[k]),
            .z_in      (pipe_z[k]),
            .meta_in   (pipe_meta[k]),
            .out_valid (pipe_valid[k+1]),
            .out_ready (pipe_ready[k+1]),
            .x_out     (pipe_x[k+1]),
            .y_out     (pipe_y[k+1]),
            .z_out     (pipe_z[k+1]),
            .meta_out  (pipe_meta[k+1])
        );
    end

    // Round, unfold and hold the result.
    pad_unfold u_unfold (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (pipe_valid[NSTEP]),
        .in_ready         (pipe_ready[NSTEP]),
        .z_in             (pipe_z[NSTEP]),
        .meta_in          (pipe_meta[NSTEP]),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_angle_centideg (m_angle_centideg),
        .m_quadrant_code  (m_quadrant_code),
        .m_at_center      (m_at_center)
    );

    // The centre point always reports angle zero in the top-right quadrant.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_at_center |-> m_angle_centideg == ANGLE_ZERO &&
                                   m_quadrant_code == QUAD_TOP_RIGHT)
        else $error("centre result carries a non-zero angle or quadrant");

    // The angle stays below a full turn.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_angle_centideg < FULL_TURN)
        else $error("angle out of range");

    // A top-left result lies between a quarter and a half turn.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_quadrant_code == QUAD_TOP_LEFT |->
            m_angle_centideg >= ANGLE_QUARTER && m_angle_centideg <= ANGLE_HALF)
        else $error("top-left angle outside its quadrant");

    // A bottom-left result lies between a half and three quarters of a turn.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_quadrant_code == QUAD_BOTTOM_LEFT |->
            m_angle_centideg >= ANGLE_HALF && m_angle_centideg <= ANGLE_3QUART)
        else $error("bottom-left angle outside its quadrant");

endmodule

### tb/point_angle_degrees_test.sv
`timescale 1ns / 100ps

module point_angle_degrees_test;
    import pad_pkg::*;

    localparam int ITERS       = 16;
    localparam int LATENCY     = ITERS + 2;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASES      = 8;
    localparam int PER_PHASE   = 55;

    // One angle result as the block presents it.
    typedef struct packed {
        logic [15:0] angle;
        logic [1:0]  quad;
        logic        centred;
    } angle_result_t;

    // One row of the directed points; typed rows carry their own result.
    typedef struct packed {
        logic [9:0]    x;
        logic [9:0]    y;
        logic          typed;
        angle_result_t res;
    } point_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_CENTER_X;
    logic [9:0]                cfg_wr_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [9:0]                s_x_coord = '0;
    logic [9:0]                s_y_coord = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [15:0]               m_angle_centideg;
    logic [1:0]                m_quadrant_code;
    logic                      m_at_center;

    // Model copy of the centre registers.
    logic [9:0] centre_x = 10'(RESET_CENTER);
    logic [9:0] centre_y = 10'(RESET_CENTER);

    angle_result_t pending_angles[$];
    angle_result_t front_angle;
    point_row_t    directed_rows[$];

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int holds_asked   = 0;
    int holds_served  = 0;
    int mismatches    = 0;
    int points_sent   = 0;
    int results_seen  = 0;
    int quiet_cycles  = 0;
    int settings_used = 1;

    always #5 aclk = ~aclk;

    point_angle_degrees #(
        .COORD_BITS(10),
        .CORDIC_ITERATIONS(ITERS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_x_coord(s_x_coord),
        .s_y_coord(s_y_coord),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_angle_centideg(m_angle_centideg),
        .m_quadrant_code(m_quadrant_code),
        .m_at_center(m_at_center)
    );

    // Angle of a point about the current centre, computed with a vectoring CORDIC.
    function automatic angle_result_t predict_angle(input logic [9:0] px, input logic [9:0] py);
        longint        dx, dy, rx, ry, rz, shx, shy;
        int unsigned   t;
        int            i;
        angle_result_t r;
        r = '0;
        dx = longint'(px) - longint'(centre_x);
        dy = longint'(centre_y) - longint'(py);
        if (dx == 0 && dy == 0) begin
            r.centred = 1'b1;
        end else if (dy == 0) begin
            r.angle = (dx > 0) ? ANGLE_ZERO : ANGLE_HALF;
            r.quad  = (dx > 0) ? QUAD_TOP_RIGHT : QUAD_BOTTOM_LEFT;
        end else if (dx == 0) begin
            r.angle = (dy > 0) ? ANGLE_QUARTER : ANGLE_3QUART;
            r.quad  = (dy > 0) ? QUAD_TOP_LEFT : QUAD_BOTTOM_RIGHT;
        end else begin
            // Fold into the first quadrant and rotate the vector onto the x axis.
            rx = ((dx < 0) ? -dx : dx) <<< FRAC_SHIFT;
            ry = ((dy < 0) ? -dy : dy) <<< FRAC_SHIFT;
            rz = 0;
            for (i = 0; i < ITERS && i < TABLE_LEN; i++) begin
                shx = rx >>> i;
                shy = ry >>> i;
                if (ry >= 0) begin
                    rx = rx + shy;
                    ry = ry - shx;
                    rz = rz + longint'(ATAN_TAB[i]);
                end else begin
                    rx = rx - shy;
                    ry = ry + shx;
                    rz = rz - longint'(ATAN_TAB[i]);
                end
            end
            if (rz < 0)
                rz = 0;
            if (rz > longint'(Z_QUARTER))
                rz = longint'(Z_QUARTER);
            t = int'((rz + longint'(Z_ROUND)) >> 8);
            // Unfold according to the signs of the offsets.
            if (dx > 0 && dy > 0) begin
                t = t;
                r.quad = QUAD_TOP_RIGHT;
            end else if (dx < 0 && dy > 0) begin
                t = ANGLE_HALF - t;
                r.quad = QUAD_TOP_LEFT;
            end else if (dx < 0) begin
                t = ANGLE_HALF + t;
                r.quad = QUAD_BOTTOM_LEFT;
            end else begin
                t = FULL_TURN - t;
                r.quad = QUAD_BOTTOM_RIGHT;
            end
            if (t >= FULL_TURN)
                t = t - FULL_TURN;
            r.angle = 16'(t);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic add_row(input int x, input int y, input logic typed,
                           input int angle, input logic [1:0] quad, input logic centred);
        point_row_t row;
        row.x = 10'(x);
        row.y = 10'(y);
        row.typed = typed;
        row.res = '{angle: 16'(angle), quad: quad, centred: centred};
        directed_rows.push_back(row);
    endtask

    // Offer one point, wait for its request to be taken and record what it must give.
    task automatic send_point(input logic [9:0] px, input logic [9:0] py,
                              input logic typed, input angle_result_t typed_res);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_x_coord <= px;
        s_y_coord <= py;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_angles.push_back(typed ? typed_res : predict_angle(px, py));
        points_sent++;
        @(negedge aclk);
    endtask

    // Random point, biased towards the centre and the two axes through it.
    task automatic random_point(output logic [9:0] px, output logic [9:0] py);
        int pick;
        pick = $urandom_range(99);
        px = 10'($urandom_range(1023));
        py = 10'($urandom_range(1023));
        if (pick < 5) begin
            px = centre_x;
            py = centre_y;
        end else if (pick < 15) begin
            px = centre_x;
        end else if (pick < 25) begin
            py = centre_y;
        end else if (pick < 32) begin
            px = centre_x + 10'($urandom_range(2)) - 10'd1;
        end else if (pick < 39) begin
            py = centre_y + 10'($urandom_range(2)) - 10'd1;
        end
    endtask

    // Wait until every request has produced its result and the pipeline has drained.
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending_angles.size() != 0)
            @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    // One register write, after which the write port is left quiet.
    task automatic write_centre(input logic [CFG_INDEX_BITS-1:0] idx, input logic [9:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_CENTER_X)
            centre_x = val;
        else
            centre_y = val;
        @(negedge aclk);
    endtask

    // Result side: random stalls, plus one long hold-off when asked for.
    initial begin
        forever begin
            @(negedge aclk);
            if (holds_served != holds_asked) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compare each result with the oldest outstanding expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_angles.size() == 0) begin
                report_mismatch($sformatf("result with nothing outstanding: angle %0d quad %0d",
                                          m_angle_centideg, m_quadrant_code));
            end else begin
                front_angle = pending_angles.pop_front();
                if (m_angle_centideg !== front_angle.angle)
                    report_mismatch($sformatf("angle %0d, expected %0d",
                                              m_angle_centideg, front_angle.angle));
                if (m_quadrant_code !== front_angle.quad)
                    report_mismatch($sformatf("quadrant %0d, expected %0d",
                                              m_quadrant_code, front_angle.quad));
                if (m_at_center !== front_angle.centred)
                    report_mismatch($sformatf("at_center %0b, expected %0b",
                                              m_at_center, front_angle.centred));
            end
        end
    end

    // Watchdog: too long without any request or result moving ends the run.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("point_angle_degrees verification failed");
            $finish;
        end
    end

    initial begin
        int            row_i;
        int            phase;
        int            n;
        logic [9:0]    px, py;
        logic [9:0]    set_x[PHASES];
        logic [9:0]    set_y[PHASES];
        angle_result_t no_res;
        no_res = '0;

        // Centre settings per phase: the four corners, the middle, a point next to a corner, then random.
        set_x = '{10'd0, 10'd1023, 10'd0, 10'd1023, 10'd512, 10'd1, 10'd0, 10'd0};
        set_y = '{10'd0, 10'd1023, 10'd1023, 10'd0, 10'd511, 10'd1022, 10'd0, 10'd0};
        set_x[6] = 10'($urandom_range(1023));
        set_y[6] = 10'($urandom_range(1023));
        set_x[7] = 10'($urandom_range(1023));
        set_y[7] = 10'($urandom_range(1023));

        // Directed points about the reset centre: centre, axes, corners, near-axis and other points.
        add_row(200, 200, 1'b1, ANGLE_ZERO, QUAD_TOP_RIGHT, 1'b1);
        add_row(300, 200, 1'b1, ANGLE_ZERO, QUAD_TOP_RIGHT, 1'b0);
        add_row(1023, 200, 1'b1, ANGLE_ZERO, QUAD_TOP_RIGHT, 1'b0);
        add_row(100, 200, 1'b1, ANGLE_HALF, QUAD_BOTTOM_LEFT, 1'b0);
        add_row(0, 200, 1'b1, ANGLE_HALF, QUAD_BOTTOM_LEFT, 1'b0);
        add_row(200, 100, 1'b1, ANGLE_QUARTER, QUAD_TOP_LEFT, 1'b0);
        add_row(200, 0, 1'b1, ANGLE_QUARTER, QUAD_TOP_LEFT, 1'b0);
        add_row(200, 300, 1'b1, ANGLE_3QUART, QUAD_BOTTOM_RIGHT, 1'b0);
        add_row(200, 1023, 1'b1, ANGLE_3QUART, QUAD_BOTTOM_RIGHT, 1'b0);
        add_row(0, 0, 1'b0, 0, 0, 1'b0);
        add_row(1023, 0, 1'b0, 0, 0, 1'b0);
        add_row(0, 1023, 1'b0, 0, 0, 1'b0);
        add_row(1023, 1023, 1'b0, 0, 0, 1'b0);
        add_row(201, 199, 1'b0, 0, 0, 1'b0);
        add_row(199, 199, 1'b0, 0, 0, 1'b0);
        add_row(199, 201, 1'b0, 0, 0, 1'b0);
        add_row(201, 201, 1'b0, 0, 0, 1'b0);
        add_row(1023, 199, 1'b0, 0, 0, 1'b0);
        add_row(1023, 201, 1'b0, 0, 0, 1'b0);
        add_row(201, 0, 1'b0, 0, 0, 1'b0);
        add_row(0, 201, 1'b0, 0, 0, 1'b0);
        add_row(682, 341, 1'b0, 0, 0, 1'b0);
        add_row(341, 682, 1'b0, 0, 0, 1'b0);

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (row_i = 0; row_i < directed_rows.size(); row_i++)
            send_point(directed_rows[row_i].x, directed_rows[row_i].y,
                       directed_rows[row_i].typed, directed_rows[row_i].res);

        // Random phases, each with its own centre and one of four handshake profiles.
        for (phase = 0; phase < PHASES; phase++) begin
            drain_pipeline();
            write_centre(REG_CENTER_X, set_x[phase]);
            write_centre(REG_CENTER_Y, set_y[phase]);
            settings_used++;
            case (phase % 4)
                0: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 61;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 61;
                end
                default: begin
                    src_idle_pct = 9;
                    sink_stall_pct = 9;
                end
            endcase
            // Hold the result side off while requests keep coming, to back the pipeline up.
            if (phase == 4)
                holds_asked++;
            for (n = 0; n < PER_PHASE; n++) begin
                random_point(px, py);
                send_point(px, py, 1'b0, no_res);
            end
        end

        drain_pipeline();
        $display("Sent %0d points and checked %0d results over %0d centre settings,",
                 points_sent, results_seen, settings_used);
        $display("with idle and stall mixes on both sides and one long output hold-off.");
        if (mismatches == 0) begin
            $display("point_angle_degrees verification clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("point_angle_degrees verification failed");
        end
        $finish;
    end

endmodule
